FILE: sv/qpd_pkg.sv
// shared types, constants and the error-product term table of the attitude torque block
package qpd_pkg;

    // working widths
    localparam int QW  = 18;  // quaternion working value, signed
    localparam int TW  = 34;  // torque and multiplier operand, signed
    localparam int AW  = 64;  // accumulator and product register
    localparam int DNW = 48;  // divider numerator and quotient
    localparam int DDW = 32;  // divider denominator

    localparam logic signed [QW-1:0] ONE_Q14 = QW'(16384);

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P = 3'd0;
    localparam logic [2:0] CFG_GAIN_D = 3'd1;
    localparam logic [2:0] CFG_LIM_X  = 3'd2;
    localparam logic [2:0] CFG_LIM_Y  = 3'd3;
    localparam logic [2:0] CFG_LIM_Z  = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_N_START, S_N_MUL, S_N_ACC, S_N_SQRT, S_N_SQWAIT, S_N_DIV, S_N_DVWAIT,
        S_E_MUL, S_E_ACC, S_E_STORE,
        S_T_MUL1, S_T_LOAD, S_T_RERR, S_T_STORE, S_T_MUL2, S_T_RND,
        S_Q_MUL, S_Q_ACC, S_L_MUL, S_L_CMP,
        S_S_SQRT, S_S_SQWAIT, S_S_MUL, S_S_DIV, S_S_DVWAIT, S_OUT
    } t_state;

    // which quaternion the normalizer works on
    typedef enum logic [1:0] {
        NS_MEAS, NS_TGT, NS_ERR
    } t_nsel;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MS_NONE, MS_SRC_SQ, MS_AD, MS_GP_QE, MS_KD_T, MS_T_SQ, MS_LIM_SQ, MS_T_LIM
    } t_msel;

    // accumulator operations
    typedef enum logic [2:0] {
        AC_HOLD, AC_LOAD, AC_ADD, AC_SUB, AC_SUB_RERR
    } t_acop;

    typedef struct packed {
        t_msel      msel;
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] idx;
        t_acop      acop;
        t_nsel      nsel;
        logic       in_take;
        logic       sq_go;
        logic       sq_shift;
        logic       div_go;
        logic       div_scale;
        logic       n_wr;
        logic       n_ident;
        logic       e_wr;
        logic       t_wr_acc;
        logic       t_wr_rnd;
        logic       scl_wr;
        logic       s_wr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic sq_done;
        logic div_done;
        logic src_zero;
        logic over;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [1:0] ai;
        logic [1:0] di;
        logic       neg;
    } t_term;

    // terms of conj(a) * d: component k, term j
    function automatic t_term e_term(input logic [1:0] k, input logic [1:0] j);
        t_term r;
        case ({k, j})
            4'b00_00: r = '{2'd0, 2'd0, 1'b0};
            4'b00_01: r = '{2'd1, 2'd1, 1'b0};
            4'b00_10: r = '{2'd2, 2'd2, 1'b0};
            4'b00_11: r = '{2'd3, 2'd3, 1'b0};
            4'b01_00: r = '{2'd0, 2'd1, 1'b0};
            4'b01_01: r = '{2'd1, 2'd0, 1'b1};
            4'b01_10: r = '{2'd2, 2'd3, 1'b1};
            4'b01_11: r = '{2'd3, 2'd2, 1'b0};
            4'b10_00: r = '{2'd0, 2'd2, 1'b0};
            4'b10_01: r = '{2'd2, 2'd0, 1'b1};
            4'b10_10: r = '{2'd3, 2'd1, 1'b1};
            4'b10_11: r = '{2'd1, 2'd3, 1'b0};
            4'b11_00: r = '{2'd0, 2'd3, 1'b0};
            4'b11_01: r = '{2'd3, 2'd0, 1'b1};
            4'b11_10: r = '{2'd1, 2'd2, 1'b1};
            4'b11_11: r = '{2'd2, 2'd1, 1'b0};
            default:  r = '{2'd0, 2'd0, 1'b0};
        endcase
        return r;
    endfunction

endpackage

FILE: sv/qpd_sqrt.sv
// iterative integer square root that consumes two radicand bits for each result bit
module qpd_sqrt import qpd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [AW-1:0] i_val,
    output logic [31:0]   o_root,
    output logic          o_done,
    output logic          o_busy
);
    localparam int STEPS = AW / 2;
    localparam int CW    = $clog2(STEPS);

    logic [AW-1:0] r_v, r_res, r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [AW-1:0] sum;

    assign sum = r_res + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one digit step
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= AW'(1) << (AW - 2);
        end else if (r_busy) begin
            if (r_v >= sum) begin
                r_v   <= r_v - sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[31:0];
    assign o_done = r_done;
    assign o_busy = r_busy;
endmodule

FILE: sv/qpd_div.sv
// restoring unsigned divider, one quotient bit per cycle
module qpd_div import qpd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [DNW-1:0] i_num,
    input  logic [DDW-1:0] i_den,
    output logic [DNW-1:0] o_quo,
    output logic           o_done,
    output logic           o_busy
);
    localparam int CW = $clog2(DNW);

    logic [DDW-1:0] r_rem, r_den;
    logic [DNW-1:0] r_q;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;
    logic [DDW:0]   trial, diff;
    logic           ge;

    assign trial = {r_rem, r_q[DNW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DNW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DDW-1:0] : trial[DDW-1:0];
            r_q   <= {r_q[DNW-2:0], ge};
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
    assign o_busy = r_busy;
endmodule

FILE: sv/qpd_datapath.sv
// registers, shared multiplier, accumulator, root and divider units of the torque block
module qpd_datapath import qpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic [111:0] i_in_data,
    input  logic         i_in_user,
    input  logic         i_cfg_valid,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [47:0]  o_out_data,
    output logic         o_out_user
);
    logic [15:0]            r_gain_p, r_gain_d;
    logic [14:0]            r_lim [3];
    logic signed [15:0]     r_tq [4];
    logic signed [15:0]     r_tr [3];
    logic signed [15:0]     r_mq [4];
    logic signed [15:0]     r_mr [3];
    logic signed [QW-1:0]   r_qa [4];
    logic signed [QW-1:0]   r_qd [4];
    logic signed [QW-1:0]   r_qe [4];
    logic signed [QW-1:0]   r_e [4];
    logic signed [TW-1:0]   r_t [3];
    logic signed [TW-1:0]   r_res [3];
    logic signed [AW-1:0]   r_acc, r_prod;
    logic                   r_scaled, r_dsign;
    logic                   r_out_valid, r_out_scl;
    logic [15:0]            r_out [3];

    logic signed [QW-1:0]   c [4];
    logic signed [QW-1:0]   c_sel;
    logic [QW-1:0]          c_mag;
    logic                   src_zero;
    logic [14:0]            lim;
    logic signed [16:0]     rerr_sel;
    logic signed [TW-1:0]   mul_a, mul_b;
    logic signed [2*TW-1:0] mul_p;
    logic [AW-1:0]          acc_mag, prod_mag, acc_r14, prod_r18;
    logic signed [QW-1:0]   e_new;
    logic signed [TW-1:0]   t_new;
    logic [AW-1:0]          sq_in;
    logic [31:0]            root;
    logic                   sq_done, sq_busy;
    logic [DNW-1:0]         div_num, quo;
    logic [DDW-1:0]         div_den;
    logic                   div_done, div_busy;
    logic signed [TW-1:0]   qs;
    logic                   over;
    logic                   out_busy;

    function automatic logic [15:0] sat16(input logic signed [TW-1:0] v);
        logic [15:0] r;
        if (v > TW'(32767))       r = 16'h7fff;
        else if (v < -TW'(32768)) r = 16'h8000;
        else                      r = v[15:0];
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= 16'd51;
            r_gain_d <= 16'd51;
            r_lim[0] <= 15'h7fff;
            r_lim[1] <= 15'h7fff;
            r_lim[2] <= 15'h7fff;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                CFG_LIM_X:  r_lim[0] <= i_cfg_data[14:0];
                CFG_LIM_Y:  r_lim[1] <= i_cfg_data[14:0];
                CFG_LIM_Z:  r_lim[2] <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // target state, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tq[0] <= 16'sd16384;
            r_tq[1] <= '0;
            r_tq[2] <= '0;
            r_tq[3] <= '0;
            r_tr[0] <= '0;
            r_tr[1] <= '0;
            r_tr[2] <= '0;
        end else if (i_cmd.in_take && !i_in_user) begin
            for (int k = 0; k < 4; k++) r_tq[k] <= i_in_data[16*k +: 16];
            for (int k = 0; k < 3; k++) r_tr[k] <= i_in_data[64 + 16*k +: 16];
        end
    end

    // measurement capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            for (int k = 0; k < 4; k++) r_mq[k] <= i_in_data[16*k +: 16];
            for (int k = 0; k < 3; k++) r_mr[k] <= i_in_data[64 + 16*k +: 16];
        end
    end

    // normalizer source, error flipped to the short way round
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (i_cmd.nsel)
                NS_MEAS: c[k] = QW'(r_mq[k]);
                NS_TGT:  c[k] = QW'(r_tq[k]);
                NS_ERR:  c[k] = r_e[0][QW-1] ? -r_e[k] : r_e[k];
                default: c[k] = '0;
            endcase
        end
    end

    assign src_zero = (c[0] == '0) && (c[1] == '0) && (c[2] == '0) && (c[3] == '0);
    assign c_sel    = c[i_cmd.idx];
    assign c_mag    = c_sel[QW-1] ? QW'(-c_sel) : c_sel;

    // smallest axis limit and rate error
    always_comb begin
        lim = r_lim[0];
        if (r_lim[1] < lim) lim = r_lim[1];
        if (r_lim[2] < lim) lim = r_lim[2];
    end

    assign rerr_sel = 17'(r_mr[i_cmd.idx]) - 17'(r_tr[i_cmd.idx]);

    // shared multiplier operands
    always_comb begin
        case (i_cmd.msel)
            MS_SRC_SQ: begin mul_a = TW'(c_sel);          mul_b = TW'(c_sel); end
            MS_AD:     begin mul_a = TW'(r_qa[i_cmd.ia]); mul_b = TW'(r_qd[i_cmd.ib]); end
            MS_GP_QE:  begin
                mul_a = TW'($signed({1'b0, r_gain_p}));
                mul_b = TW'(r_qe[2'(i_cmd.idx + 2'd1)]);
            end
            MS_KD_T:   begin mul_a = TW'($signed({1'b0, r_gain_d})); mul_b = r_t[i_cmd.idx]; end
            MS_T_SQ:   begin mul_a = r_t[i_cmd.idx];      mul_b = r_t[i_cmd.idx]; end
            MS_LIM_SQ: begin
                mul_a = TW'($signed({1'b0, lim}));
                mul_b = TW'($signed({1'b0, lim}));
            end
            MS_T_LIM:  begin mul_a = r_t[i_cmd.idx]; mul_b = TW'($signed({1'b0, lim})); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.msel != MS_NONE) r_prod <= mul_p[AW-1:0];
        case (i_cmd.acop)
            AC_LOAD:     r_acc <= r_prod;
            AC_ADD:      r_acc <= r_acc + r_prod;
            AC_SUB:      r_acc <= r_acc - r_prod;
            AC_SUB_RERR: r_acc <= r_acc - (AW'(rerr_sel) <<< 10);
            default:     r_acc <= r_acc;
        endcase
    end

    // round half away from zero by 2^14 and 2^18
    assign acc_mag  = r_acc[AW-1] ? -r_acc : r_acc;
    assign prod_mag = r_prod[AW-1] ? -r_prod : r_prod;
    assign acc_r14  = (acc_mag + AW'(1 << 13)) >> 14;
    assign prod_r18 = (prod_mag + AW'(1 << 17)) >> 18;
    assign e_new    = r_acc[AW-1] ? -QW'(acc_r14) : QW'(acc_r14);
    assign t_new    = r_prod[AW-1] ? -TW'(prod_r18) : TW'(prod_r18);

    // square root and divider
    assign sq_in   = i_cmd.sq_shift ? (r_acc << 16) : r_acc;
    assign div_num = i_cmd.div_scale ? ((DNW'(prod_mag) << 1) + DNW'(root))
                                     : ((DNW'(c_mag) << 23) + DNW'(root));
    assign div_den = {root[DDW-2:0], 1'b0};

    qpd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sq_go),
        .i_val   (sq_in),
        .o_root  (root),
        .o_done  (sq_done),
        .o_busy  (sq_busy)
    );

    qpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done),
        .o_busy  (div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) r_dsign <= i_cmd.div_scale ? r_prod[AW-1] : c_sel[QW-1];
    end

    assign qs = r_dsign ? -TW'(quo) : TW'(quo);

    // working quaternions and torque vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.n_wr) begin
            case (i_cmd.nsel)
                NS_MEAS: r_qa[i_cmd.idx] <= QW'(qs);
                NS_TGT:  r_qd[i_cmd.idx] <= QW'(qs);
                NS_ERR:  r_qe[i_cmd.idx] <= QW'(qs);
                default: ;
            endcase
        end
        if (i_cmd.n_ident) begin
            for (int k = 0; k < 4; k++) begin
                case (i_cmd.nsel)
                    NS_MEAS: r_qa[k] <= (k == 0) ? ONE_Q14 : '0;
                    NS_TGT:  r_qd[k] <= (k == 0) ? ONE_Q14 : '0;
                    NS_ERR:  r_qe[k] <= (k == 0) ? ONE_Q14 : '0;
                    default: ;
                endcase
            end
        end
        if (i_cmd.e_wr)     r_e[i_cmd.idx]   <= e_new;
        if (i_cmd.t_wr_acc) r_t[i_cmd.idx]   <= r_acc[TW-1:0];
        if (i_cmd.t_wr_rnd) r_t[i_cmd.idx]   <= t_new;
        if (i_cmd.s_wr)     r_res[i_cmd.idx] <= qs;
        if (i_cmd.scl_wr)   r_scaled         <= over;
    end

    assign over = $unsigned(r_acc) > $unsigned(r_prod);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int k = 0; k < 3; k++) r_out[k] <= sat16(r_scaled ? r_res[k] : r_t[k]);
            r_out_scl <= r_scaled;
        end
    end

    assign out_busy    = r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out[2], r_out[1], r_out[0]};
    assign o_out_user  = r_out_scl;

    assign o_stat = '{sq_done:  sq_done,
                      div_done: div_done,
                      src_zero: src_zero,
                      over:     over,
                      out_busy: out_busy};

    // units are only started when free, results only stored when ready
    a_sq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_go |-> !sq_busy) else $error("root started while busy");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> !div_busy) else $error("divide started while busy");
    a_quo_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.n_wr || i_cmd.s_wr) |-> div_done) else $error("quotient stored early");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !out_busy) else $error("pending result overwritten");
endmodule

FILE: sv/qpd_ctrl.sv
// sequencer that steps the datapath through normalizing, error product, torque and limiting
module qpd_ctrl import qpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_cmd,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state     r_state, n_state;
    t_nsel      r_nsel, n_nsel;
    logic [1:0] r_i, n_i, r_j, n_j;
    t_term      term;

    assign term = e_term(r_i, r_j);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nsel  <= NS_MEAS;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_nsel  <= n_nsel;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_nsel  = r_nsel;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd           = '0;
        o_cmd.msel      = MS_NONE;
        o_cmd.acop      = AC_HOLD;
        o_cmd.nsel      = r_nsel;
        o_cmd.idx       = r_i;
        o_in_ready      = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_take = i_in_valid;
                if (i_in_valid && i_in_cmd) begin
                    n_nsel  = NS_MEAS;
                    n_i     = '0;
                    n_state = S_N_START;
                end
            end
            S_N_START: begin
                n_i = '0;
                if (i_stat.src_zero) begin
                    o_cmd.n_ident = 1'b1;
                    case (r_nsel)
                        NS_MEAS: begin n_nsel = NS_TGT; n_state = S_N_START; end
                        NS_TGT:  begin n_j = '0; n_state = S_E_MUL; end
                        default: n_state = S_T_MUL1;
                    endcase
                end else begin
                    n_state = S_N_MUL;
                end
            end
            S_N_MUL: begin
                o_cmd.msel = MS_SRC_SQ;
                n_state    = S_N_ACC;
            end
            S_N_ACC: begin
                o_cmd.acop = (r_i == 2'd0) ? AC_LOAD : AC_ADD;
                if (r_i == 2'd3) begin
                    n_i     = '0;
                    n_state = S_N_SQRT;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_N_MUL;
                end
            end
            S_N_SQRT: begin
                o_cmd.sq_go    = 1'b1;
                o_cmd.sq_shift = 1'b1;
                n_state        = S_N_SQWAIT;
            end
            S_N_SQWAIT: begin
                if (i_stat.sq_done) n_state = S_N_DIV;
            end
            S_N_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_N_DVWAIT;
            end
            S_N_DVWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.n_wr = 1'b1;
                    if (r_i == 2'd3) begin
                        n_i = '0;
                        case (r_nsel)
                            NS_MEAS: begin n_nsel = NS_TGT; n_state = S_N_START; end
                            NS_TGT:  begin n_j = '0; n_state = S_E_MUL; end
                            default: n_state = S_T_MUL1;
                        endcase
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_state = S_N_DIV;
                    end
                end
            end
            S_E_MUL: begin
                o_cmd.msel = MS_AD;
                o_cmd.ia   = term.ai;
                o_cmd.ib   = term.di;
                n_state    = S_E_ACC;
            end
            S_E_ACC: begin
                if (r_j == 2'd0)   o_cmd.acop = AC_LOAD;
                else if (term.neg) o_cmd.acop = AC_SUB;
                else               o_cmd.acop = AC_ADD;
                if (r_j == 2'd3) begin
                    n_j     = '0;
                    n_state = S_E_STORE;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_E_MUL;
                end
            end
            S_E_STORE: begin
                o_cmd.e_wr = 1'b1;
                if (r_i == 2'd3) begin
                    n_i     = '0;
                    n_nsel  = NS_ERR;
                    n_state = S_N_START;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_E_MUL;
                end
            end
            S_T_MUL1: begin
                o_cmd.msel = MS_GP_QE;
                n_state    = S_T_LOAD;
            end
            S_T_LOAD: begin
                o_cmd.acop = AC_LOAD;
                n_state    = S_T_RERR;
            end
            S_T_RERR: begin
                o_cmd.acop = AC_SUB_RERR;
                n_state    = S_T_STORE;
            end
            S_T_STORE: begin
                o_cmd.t_wr_acc = 1'b1;
                n_state        = S_T_MUL2;
            end
            S_T_MUL2: begin
                o_cmd.msel = MS_KD_T;
                n_state    = S_T_RND;
            end
            S_T_RND: begin
                o_cmd.t_wr_rnd = 1'b1;
                if (r_i == 2'd2) begin
                    n_i     = '0;
                    n_state = S_Q_MUL;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_T_MUL1;
                end
            end
            S_Q_MUL: begin
                o_cmd.msel = MS_T_SQ;
                n_state    = S_Q_ACC;
            end
            S_Q_ACC: begin
                o_cmd.acop = (r_i == 2'd0) ? AC_LOAD : AC_ADD;
                if (r_i == 2'd2) begin
                    n_i     = '0;
                    n_state = S_L_MUL;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_Q_MUL;
                end
            end
            S_L_MUL: begin
                o_cmd.msel = MS_LIM_SQ;
                n_state    = S_L_CMP;
            end
            S_L_CMP: begin
                o_cmd.scl_wr = 1'b1;
                n_state      = i_stat.over ? S_S_SQRT : S_OUT;
            end
            S_S_SQRT: begin
                o_cmd.sq_go = 1'b1;
                n_state     = S_S_SQWAIT;
            end
            S_S_SQWAIT: begin
                if (i_stat.sq_done) n_state = S_S_MUL;
            end
            S_S_MUL: begin
                o_cmd.msel = MS_T_LIM;
                n_state    = S_S_DIV;
            end
            S_S_DIV: begin
                o_cmd.div_go    = 1'b1;
                o_cmd.div_scale = 1'b1;
                n_state         = S_S_DVWAIT;
            end
            S_S_DVWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.s_wr = 1'b1;
                    if (r_i == 2'd2) begin
                        n_i     = '0;
                        n_state = S_OUT;
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_state = S_S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: sv/quaternion_pd_attitude_torque.sv
// top level of the quaternion feedback pd attitude torque block
// A target item (tuser 0) stores the desired quaternion and body rate
// and gives no result. A measurement item (tuser 1) normalizes the measured and the
// target quaternion, forms the error quaternion, takes the short way round,
// normalizes it, and returns kd*(kp*qerr_xyz - 1024*rate_err)/2^18, scaled down to the
// smallest axis limit when its norm is larger (tuser 1 on the result). The time of one
// measurement item is set by the shared bit-serial divider (at most 12 quotients, 15
// when the torque is scaled) and the square root unit (at most 3 roots, 4 when scaled);
// a new item is accepted once the previous one has reached the output register, which
// holds its result until taken.
module quaternion_pd_attitude_torque import qpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // torque_out_x, torque_out_y, torque_out_z
    output logic         m_axis_tuser,   // was_scaled
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    qpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qpd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );
endmodule

FILE: test/testbench.sv
// testbench for the quaternion pd attitude torque block: scoreboard with bit-exact predictor
module testbench import qpd_pkg::*;;

    localparam logic CMD_TARGET  = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;
    // index past the last register, written to check that it is ignored
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int ITEM_LATENCY = 1200;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    // expected torque item
    typedef struct {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tz;
        logic        scaled;
    } t_torque;

    // predictor of the attitude torque and store of pending torque items
    class t_torque_scoreboard;
        longint unsigned kp, kd, lim[3];
        longint tgt_quat[4], tgt_rate[3];
        t_torque pending[$];
        int errors;

        function new();
            kp = 51; kd = 51;
            lim[0] = 32767; lim[1] = 32767; lim[2] = 32767;
            tgt_quat[0] = 16384; tgt_quat[1] = 0; tgt_quat[2] = 0; tgt_quat[3] = 0;
            tgt_rate[0] = 0; tgt_rate[1] = 0; tgt_rate[2] = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_GAIN_P: kp = val;
                CFG_GAIN_D: kd = val;
                CFG_LIM_X:  lim[0] = val[14:0];
                CFG_LIM_Y:  lim[1] = val[14:0];
                CFG_LIM_Z:  lim[2] = val[14:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'h1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // round to nearest, halves away from zero
        function longint round_div(longint num, longint unsigned den);
            longint unsigned m, q;
            m = (num < 0) ? longint'(-num) : num;
            q = (2 * m + den) / (2 * den);
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void unit_quat(input longint c[4], output longint o[4]);
            longint unsigned s, n;
            s = 0;
            for (int i = 0; i < 4; i++) s += longint'(c[i] * c[i]);
            if (s == 0) begin
                o[0] = 16384; o[1] = 0; o[2] = 0; o[3] = 0;
            end else begin
                n = int_sqrt(s << 16);
                for (int i = 0; i < 4; i++) o[i] = round_div(c[i] * (64'sd1 << 22), n);
            end
        endfunction

        function logic [15:0] clamp16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_item(logic cmd, logic [111:0] d);
            longint raw[4], a[4], t[4], e[4], qe[4], tq[3], rerr, diff;
            longint unsigned sumsq, lmin, n;
            t_torque r;
            if (cmd == CMD_TARGET) begin
                for (int i = 0; i < 4; i++) tgt_quat[i] = $signed(d[16*i +: 16]);
                for (int i = 0; i < 3; i++) tgt_rate[i] = $signed(d[64 + 16*i +: 16]);
                return;
            end
            for (int i = 0; i < 4; i++) raw[i] = $signed(d[16*i +: 16]);
            unit_quat(raw, a);
            unit_quat(tgt_quat, t);
            // conjugate of measured times target
            e[0] = round_div(a[0]*t[0] + a[1]*t[1] + a[2]*t[2] + a[3]*t[3], 16384);
            e[1] = round_div(a[0]*t[1] - t[0]*a[1] - (a[2]*t[3] - a[3]*t[2]), 16384);
            e[2] = round_div(a[0]*t[2] - t[0]*a[2] - (a[3]*t[1] - a[1]*t[3]), 16384);
            e[3] = round_div(a[0]*t[3] - t[0]*a[3] - (a[1]*t[2] - a[2]*t[1]), 16384);
            if (e[0] < 0) for (int i = 0; i < 4; i++) e[i] = -e[i];
            unit_quat(e, qe);
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                rerr = longint'($signed(d[64 + 16*i +: 16])) - tgt_rate[i];
                diff = longint'(kp) * qe[1+i] - rerr * 1024;
                tq[i] = round_div(diff * longint'(kd), 64'd1 << 18);
                sumsq += longint'(tq[i] * tq[i]);
            end
            lmin = lim[0];
            if (lim[1] < lmin) lmin = lim[1];
            if (lim[2] < lmin) lmin = lim[2];
            if (sumsq > lmin * lmin) begin
                n = int_sqrt(sumsq);
                r.tx = clamp16(round_div(tq[0] * longint'(lmin), n));
                r.ty = clamp16(round_div(tq[1] * longint'(lmin), n));
                r.tz = clamp16(round_div(tq[2] * longint'(lmin), n));
                r.scaled = 1'b1;
            end else begin
                r.tx = clamp16(tq[0]);
                r.ty = clamp16(tq[1]);
                r.tz = clamp16(tq[2]);
                r.scaled = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_torque(logic [47:0] d, logic scaled);
            t_torque x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected torque item %h scaled %b", $time, d, scaled);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[15:0] !== x.tx) begin
                $display("%0t: torque x expected %h actual %h", $time, x.tx, d[15:0]);
                errors++;
            end
            if (d[31:16] !== x.ty) begin
                $display("%0t: torque y expected %h actual %h", $time, x.ty, d[31:16]);
                errors++;
            end
            if (d[47:32] !== x.tz) begin
                $display("%0t: torque z expected %h actual %h", $time, x.tz, d[47:32]);
                errors++;
            end
            if (scaled !== x.scaled) begin
                $display("%0t: scaled flag expected %b actual %b", $time, x.scaled, scaled);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    t_torque_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    quaternion_pd_attitude_torque dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: accepted items, register writes and torque items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_torque(m_axis_tdata, m_axis_tuser);
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_gains_limits(logic [15:0] kp, logic [15:0] kd, logic [14:0] lx,
                                    logic [14:0] ly, logic [14:0] lz);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_LIM_X, {1'b0, lx});
        write_reg(CFG_LIM_Y, {1'b0, ly});
        write_reg(CFG_LIM_Z, {1'b0, lz});
    endtask

    // one item; valid stays high into the next item unless a gap is drawn
    task automatic send_item(logic cmd, logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                             logic [15:0] qz, logic [15:0] rx, logic [15:0] ry,
                             logic [15:0] rz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {rz, ry, rx, qz, qy, qx, qw};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (ITEM_LATENCY) @(negedge i_clk);
    endtask

    // quaternion part: full range, within +-10000, zero, or extreme
    function automatic logic [15:0] rand_quat_part();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return 16'($urandom);
        if (sel < 8) return 16'($signed($urandom_range(0, 20000)) - 10000);
        if (sel == 8) return 16'h0000;
        return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endfunction

    function automatic logic [15:0] rand_rate();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return 16'($urandom);
        if (sel < 9) return 16'($signed($urandom_range(0, 4000)) - 2000);
        return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endfunction

    task automatic random_items(int count, bit pause_mid);
        logic cmd;
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) begin
                s_axis_tvalid = 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
            cmd = ($urandom_range(99) < 30) ? CMD_TARGET : CMD_MEASURE;
            if ($urandom_range(9) == 0)
                send_item(cmd, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          rand_rate(), rand_rate(), rand_rate());
            else
                send_item(cmd, rand_quat_part(), rand_quat_part(), rand_quat_part(),
                          rand_quat_part(), rand_rate(), rand_rate(), rand_rate());
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_TARGET;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN_P;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset state and special cases
        send_item(CMD_MEASURE, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(CMD_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
                  16'h0100);
        // error scalar exactly zero
        send_item(CMD_MEASURE, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(CMD_TARGET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff,
                  16'h8000);
        send_item(CMD_MEASURE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                  16'h7fff);
        // target negated: error scalar negative
        send_item(CMD_TARGET, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(CMD_MEASURE, 16'h3ff0, 16'h0400, 16'hfc00, 16'h0200, 16'h0010, 16'hfff0,
                  16'h0000);
        send_item(CMD_TARGET, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h1234, 16'hedcb,
                  16'h0000);
        send_item(CMD_MEASURE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000);
        send_item(CMD_MEASURE, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'hffff,
                  16'hffff);
        drain();

        // extremes of gains, ignored write, zero limit
        write_reg(CFG_UNUSED, 16'hffff);
        set_gains_limits(16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 15'h7fff);
        send_item(CMD_MEASURE, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h8000);
        send_item(CMD_MEASURE, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        random_items(80, 1'b0);
        drain();
        set_gains_limits(16'h0100, 16'h0100, 15'h0000, 15'h7fff, 15'h7fff);
        send_item(CMD_TARGET, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(CMD_MEASURE, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000);
        send_item(CMD_MEASURE, 16'h2000, 16'h1000, 16'h0000, 16'h0000, 16'h0040, 16'h0000,
                  16'h0000);
        drain();

        // random phases over settings and idling styles
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (ph)
                0: set_gains_limits(16'd51, 16'd51, 15'h7fff, 15'h7fff, 15'h7fff);
                1: set_gains_limits(16'h0000, 16'h0800, 15'h2000, 15'h7fff, 15'h1000);
                2: set_gains_limits(16'h0800, 16'h0000, 15'h0001, 15'h0001, 15'h0001);
                3: set_gains_limits(16'h0400, 16'h0400, 15'h7fff, 15'h0800, 15'h7fff);
                4: set_gains_limits(16'hffff, 16'h0100, 15'h7fff, 15'h7fff, 15'h0000);
                default: set_gains_limits(16'($urandom), 16'($urandom_range(0, 2048)),
                                          15'($urandom), 15'($urandom), 15'($urandom));
            endcase
            random_items(85, ph == 2);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
